// File: src/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared types and constants for the fixed-point decimal text formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

    localparam int MAX_SCALE  = 18;
    localparam int MAX_DIGITS = 20;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    // 64 shift steps of the double-dabble, split over the pipeline stages
    localparam int CONV_STAGES = 8;
    localparam int BITS_PER_STAGE = 64 / CONV_STAGES;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [63:0] amount;
        logic [7:0]         decimals;
        logic [7:0]         code_first;
        logic [7:0]         code_second;
        logic [7:0]         code_third;
        logic [7:0]         code_terminator;
        logic [15:0]        buffer_size;
        logic               query_only;
    } in_item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       has_char;
        logic       last;
        logic [1:0] status;
        logic [6:0] required_length;
    } out_item_t;

    // Item as it travels through the conversion pipeline
    typedef struct packed {
        logic [63:0]      bin;      // remaining magnitude bits, msb first
        logic [BCD_W-1:0] bcd;
        logic             negative;
        logic             invalid;
        logic [4:0]       scale;
        logic [23:0]      code;
        logic [15:0]      capacity;
        logic             query;
    } conv_t;

    // Fully converted item handed to the character emitter
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [4:0]       ndig;
        logic             negative;
        logic             invalid;
        logic [4:0]       scale;
        logic [23:0]      code;
        logic [15:0]      capacity;
        logic             query;
    } job_t;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= CH_A) && (b <= CH_Z);
    endfunction

    // One double-dabble step: add 3 to digits >= 5, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v,
                                                input logic b);
        logic [BCD_W-1:0] t;
        t = v;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (t[4*d +: 4] >= 4'd5) t[4*d +: 4] = t[4*d +: 4] + 4'd3;
        end
        return {t[BCD_W-2:0], b};
    endfunction

endpackage

// File: src/fixed_point_decimal_text_formatter_top.sv
// Path: an accepted input beat passes the input stage, 8 conversion stages, the emitter job
//   register and the output register before the first output beat appears.
// Throughput: one beat a cycle while out_stall is low, for texts of 5..25 characters or one
//   status-only beat, then the next item is loaded; the converter takes one item a cycle unless stalled.
// Reset: rst_n clears all valid bits and the emitter state asynchronously.
// ----------------------------------------------------------------------------
// fixed_point_decimal_text_formatter_top
// Formats a signed amount in minor units as "CCC [-]int[.frac]" ASCII beats, or one status beat.
// ----------------------------------------------------------------------------
module fixed_point_decimal_text_formatter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fpdf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fpdf_pkg::out_item_t out_data
);
    import fpdf_pkg::*;

    // Pipeline stall: the whole converter holds while the emitter is busy
    // and the last stage holds an item.
    logic  pipe_stall;
    logic  emit_busy;

    conv_t s0_next, s0_reg;
    logic  s0_valid_reg;

    logic  [CONV_STAGES:0] v;
    conv_t d [CONV_STAGES+1];

    job_t  job;
    logic  [4:0] ndig;

    // Validate the arguments and form the magnitude in unsigned arithmetic
    always_comb
    begin
        s0_next.bin      = in_data.amount[63] ? (64'd0 - in_data.amount) : in_data.amount;
        s0_next.bcd      = '0;
        s0_next.negative = in_data.amount[63];
        s0_next.invalid  = !is_upper(in_data.code_first) || !is_upper(in_data.code_second)
                        || !is_upper(in_data.code_third) || (in_data.code_terminator != 8'd0)
                        || (in_data.decimals > 8'(MAX_SCALE));
        s0_next.scale    = in_data.decimals[4:0];
        s0_next.code     = {in_data.code_first, in_data.code_second, in_data.code_third};
        s0_next.capacity = in_data.buffer_size;
        s0_next.query    = in_data.query_only;
    end

    assign pipe_stall = v[CONV_STAGES] && emit_busy;
    assign in_stall   = pipe_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s0_valid_reg <= 1'b0;
        else if (!pipe_stall) s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!pipe_stall) s0_reg <= s0_next;
    end

    assign v[0] = s0_valid_reg;
    assign d[0] = s0_reg;

    for (genvar g = 0; g < CONV_STAGES; g++) begin : g_conv
        fpdf_conv_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid     (v[g]),
            .data      (d[g]),
            .stall     (pipe_stall),
            .out_valid (v[g+1]),
            .out_data  (d[g+1])
        );
    end

    // Count significant digits: position of the top nonzero BCD digit
    always_comb
    begin
        ndig = 5'd1;
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (d[CONV_STAGES].bcd[4*i +: 4] != 4'd0) ndig = 5'(i + 1);
        end
        job.bcd      = d[CONV_STAGES].bcd;
        job.ndig     = ndig;
        job.negative = d[CONV_STAGES].negative;
        job.invalid  = d[CONV_STAGES].invalid;
        job.scale    = d[CONV_STAGES].scale;
        job.code     = d[CONV_STAGES].code;
        job.capacity = d[CONV_STAGES].capacity;
        job.query    = d[CONV_STAGES].query;
    end

    fpdf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (v[CONV_STAGES]),
        .job       (job),
        .stall     (emit_busy),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );
endmodule

// File: src/fpdf_conv_stage.sv
// ----------------------------------------------------------------------------
// fpdf_conv_stage
// One pipeline stage of the binary to BCD converter: a group of dabble steps.
// ----------------------------------------------------------------------------
module fpdf_conv_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  fpdf_pkg::conv_t data,
    input  logic            stall,
    output logic            out_valid,
    output fpdf_pkg::conv_t out_data
);
    import fpdf_pkg::*;

    conv_t stage_next;
    conv_t data_reg;
    logic  valid_reg;

    always_comb
    begin
        stage_next = data;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            stage_next.bcd = dabble(stage_next.bcd, stage_next.bin[63]);
            stage_next.bin = {stage_next.bin[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (!stall) valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (!stall) data_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// File: src/fpdf_emit.sv
// ----------------------------------------------------------------------------
// fpdf_emit
// Character emitter: walks the text of one converted item, one beat a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module fpdf_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  fpdf_pkg::job_t       job,
    output logic                 stall,
    output logic                 out_valid,
    output fpdf_pkg::out_item_t  out_data,
    input  logic                 out_stall
);
    import fpdf_pkg::*;

    job_t      job_reg;
    logic      busy_reg;
    logic [5:0] pos_reg, pos_next;
    logic      ov_reg;
    out_item_t od_reg;

    // Text layout derived from the held job
    logic [6:0] len;
    logic [5:0] pre;      // code, space, sign
    logic       frac_form;
    logic [5:0] body_len;
    logic [7:0] ch;
    logic [5:0] k;
    logic [4:0] di;
    logic [4:0] zpad;
    logic [5:0] int_cnt;
    logic       single;
    logic       advance;
    logic       ovl_free;

    always_comb
    begin
        pre       = job_reg.negative ? 6'd5 : 6'd4;
        frac_form = {1'b0, job_reg.scale} >= {1'b0, job_reg.ndig};
        zpad      = job_reg.scale - job_reg.ndig;
        int_cnt   = {1'b0, job_reg.ndig} - {1'b0, job_reg.scale};
        if (frac_form)
            body_len = 6'd2 + {1'b0, job_reg.scale};
        else
            body_len = {1'b0, job_reg.ndig} + ((job_reg.scale != 5'd0) ? 6'd1 : 6'd0);
        len    = {1'b0, pre} + {1'b0, body_len};
        single = job_reg.invalid || job_reg.query
              || ({1'b0, job_reg.capacity} < {10'd0, len} + 17'd1);

        k  = pos_reg - pre;
        di = 5'd0;
        ch = CH_ZERO;
        if (pos_reg == 6'd0)      ch = job_reg.code[23:16];
        else if (pos_reg == 6'd1) ch = job_reg.code[15:8];
        else if (pos_reg == 6'd2) ch = job_reg.code[7:0];
        else if (pos_reg == 6'd3) ch = CH_SPACE;
        else if (pos_reg == 6'd4 && job_reg.negative) ch = CH_MINUS;
        else if (frac_form) begin
            if (k == 6'd0)       ch = CH_ZERO;
            else if (k == 6'd1)  ch = CH_POINT;
            else if (k < 6'd2 + {1'b0, zpad}) ch = CH_ZERO;
            else begin
                di = 5'(job_reg.ndig - 5'(k - 6'd2 - {1'b0, zpad}) - 5'd1);
                ch = CH_ZERO | {4'd0, job_reg.bcd[4*di +: 4]};
            end
        end else begin
            if (job_reg.scale != 5'd0 && k == int_cnt) ch = CH_POINT;
            else begin
                if (job_reg.scale != 5'd0 && k > int_cnt)
                    di = 5'(job_reg.ndig - 5'(k - 6'd1) - 5'd1);
                else
                    di = 5'(job_reg.ndig - 5'(k) - 5'd1);
                ch = CH_ZERO | {4'd0, job_reg.bcd[4*di +: 4]};
            end
        end
    end

    assign ovl_free = !ov_reg || !out_stall;
    assign advance  = busy_reg && ovl_free;
    assign stall    = busy_reg;
    assign pos_next = pos_reg + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            pos_reg  <= 6'd0;
        end else begin
            if (ovl_free) ov_reg <= advance;
            if (!busy_reg) begin
                if (valid) begin
                    busy_reg <= 1'b1;
                    pos_reg  <= 6'd0;
                end
            end else if (advance) begin
                if (single || {1'b0, pos_next} == len) busy_reg <= 1'b0;
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && valid) job_reg <= job;
        if (advance) begin
            if (single) begin
                od_reg.text_char <= 8'd0;
                od_reg.has_char  <= 1'b0;
                od_reg.last      <= 1'b1;
                od_reg.status    <= job_reg.invalid ? ST_INVALID
                                  : (job_reg.query ? ST_OK : ST_CAPACITY);
                od_reg.required_length <= job_reg.invalid ? 7'd0 : len + 7'd1;
            end else begin
                od_reg.text_char <= ch;
                od_reg.has_char  <= 1'b1;
                od_reg.last      <= ({1'b0, pos_next} == len);
                od_reg.status    <= ST_OK;
                od_reg.required_length <= len + 7'd1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

// File: verif/fixed_point_decimal_text_formatter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_text_formatter_top_tb
// Drives amount/scale/code/capacity beats into the formatter and checks every
// output beat against a local text builder, with random gaps on both sides.
// ----------------------------------------------------------------------------
module fixed_point_decimal_text_formatter_top_tb;
    import fpdf_pkg::*;

    localparam int  RANDOM_ITEMS = 460;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  DRAIN_CYCLES = 64;
    localparam int  HOLD_CYCLES  = 300;
    // a capacity of this value is replaced by the required length, sometimes plus slack
    localparam logic [15:0] CAP_EXACT = 16'hFFFE;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    out_item_t text_beats_q[$];
    int        fail_count;
    int        cycle_count;
    bit        sending_done;
    bit        hold_request;

    // one directed row: the input beat and, where obvious, the single expected beat
    typedef struct {
        in_item_t  item;
        bit        has_fixed;
        out_item_t fixed;
    } row_t;

    fixed_point_decimal_text_formatter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Build the expected beats for one item: the formatted text, or one status beat.
    function automatic void format_amount(input in_item_t it, ref out_item_t beats[$]);
        logic [63:0] mag;
        logic [7:0]  digs[$];
        logic [7:0]  txt[$];
        logic [6:0]  need;
        out_item_t   b;
        bit          neg;
        int          scale;
        beats.delete();
        b = '0;
        b.last = 1'b1;
        scale = it.decimals;
        if (!(it.code_first inside {[CH_A:CH_Z]}) || !(it.code_second inside {[CH_A:CH_Z]})
            || !(it.code_third inside {[CH_A:CH_Z]}) || it.code_terminator != 8'd0
            || scale > MAX_SCALE)
        begin
            b.status = ST_INVALID;
            beats.push_back(b);
            return;
        end
        neg = it.amount[63];
        mag = neg ? 64'd0 - it.amount : it.amount;
        // least significant digit first
        do
        begin
            digs.push_back(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0 && digs.size() < MAX_DIGITS);
        txt = {it.code_first, it.code_second, it.code_third, CH_SPACE};
        if (neg) txt.push_back(CH_MINUS);
        if (scale >= digs.size())
        begin
            txt.push_back(CH_ZERO);
            txt.push_back(CH_POINT);
            for (int i = digs.size(); i < scale; i++) txt.push_back(CH_ZERO);
            for (int i = digs.size(); i > 0; i--) txt.push_back(digs[i-1]);
        end
        else
        begin
            for (int i = digs.size(); i > 0; i--)
            begin
                txt.push_back(digs[i-1]);
                if (scale != 0 && i == scale + 1) txt.push_back(CH_POINT);
            end
        end
        need = 7'(txt.size() + 1);
        b.required_length = need;
        if (it.query_only || it.buffer_size < need)
        begin
            b.status = it.query_only ? ST_OK : ST_CAPACITY;
            beats.push_back(b);
            return;
        end
        foreach (txt[i])
        begin
            b.text_char = txt[i];
            b.has_char  = 1'b1;
            b.last      = (i == txt.size() - 1);
            b.status    = ST_OK;
            beats.push_back(b);
        end
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'(CH_A + $urandom_range(0, 25));
    endfunction

    function automatic in_item_t make_item(input logic signed [63:0] amt, input int dec,
                                           input logic [15:0] cap, input bit q);
        in_item_t it;
        it.amount          = amt;
        it.decimals        = 8'(dec);
        it.code_first      = "U";
        it.code_second     = "S";
        it.code_third      = "D";
        it.code_terminator = 8'd0;
        it.buffer_size     = cap;
        it.query_only      = q;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       sel;
        it.amount = {$urandom(), $urandom()};
        // shrink four in ten magnitudes so that short digit strings get exercised
        sel = $urandom_range(0, 9);
        if (sel < 4) it.amount = it.amount >>> $urandom_range(0, 63);
        it.decimals = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 18));
        it.code_first  = pick_letter();
        it.code_second = pick_letter();
        it.code_third  = pick_letter();
        it.code_terminator = 8'd0;
        sel = $urandom_range(0, 19);
        if (sel == 0) it.code_first = 8'($urandom());
        if (sel == 1) it.code_second = 8'($urandom());
        if (sel == 2) it.code_third = 8'($urandom());
        if (sel == 3) it.code_terminator = 8'($urandom());
        sel = $urandom_range(0, 9);
        if (sel == 0)      it.buffer_size = 16'($urandom());
        else if (sel == 1) it.buffer_size = 16'($urandom_range(0, 44));
        else               it.buffer_size = CAP_EXACT;
        it.query_only = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    // Replace the exact-fit marker by the true length, sometimes plus slack.
    function automatic in_item_t fit_capacity(input in_item_t it);
        out_item_t probe[$];
        in_item_t  q;
        if (it.buffer_size != CAP_EXACT) return it;
        q = it;
        q.query_only = 1'b1;
        format_amount(q, probe);
        it.buffer_size = 16'(probe[0].required_length) + 16'($urandom_range(0, 1));
        if (probe[0].status == ST_INVALID) it.buffer_size = 16'($urandom());
        return it;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_beat(input in_item_t it);
        out_item_t beats[$];
        int        g;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        format_amount(it, beats);
        foreach (beats[i]) text_beats_q.push_back(beats[i]);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Sender: directed table, then random beats.
    initial
    begin
        row_t      rows[$];
        row_t      r;
        out_item_t ob;
        in_item_t  it;
        in_valid     = 1'b0;
        in_data      = '0;
        rst_n        = 1'b0;
        fail_count   = 0;
        sending_done = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        ob = '0;
        ob.last = 1'b1;
        // zero, extremes, padding and point placement
        r.has_fixed = 0;
        r.item = make_item(64'sd0, 0, 16'd100, 0);                       rows.push_back(r);
        r.item = make_item(64'sd0, 18, 16'd100, 0);                      rows.push_back(r);
        r.item = make_item(64'sh7FFF_FFFF_FFFF_FFFF, 0, 16'hFFFF, 0);    rows.push_back(r);
        r.item = make_item(64'sh8000_0000_0000_0000, 0, 16'd100, 0);     rows.push_back(r);
        r.item = make_item(64'sh8000_0000_0000_0000, 18, 16'd100, 0);    rows.push_back(r);
        r.item = make_item(-64'sd1, 18, 16'd100, 0);                     rows.push_back(r);
        r.item = make_item(64'sd12345, 2, 16'd100, 0);                   rows.push_back(r);
        r.item = make_item(64'sd12345, 5, 16'd100, 0);                   rows.push_back(r);
        r.item = make_item(64'sd12345, 4, 16'd100, 0);                   rows.push_back(r);
        r.item = make_item(-64'sd5, 1, 16'd100, 0);                      rows.push_back(r);
        r.item = make_item(64'sd99, 0, 16'd100, 0);                      rows.push_back(r);
        // query mode: length only; "USD 0" is 5 chars plus terminator
        r.has_fixed = 1;
        ob.status = ST_OK; ob.required_length = 7'd6;
        r.item = make_item(64'sd0, 0, 16'd0, 1);    r.fixed = ob;        rows.push_back(r);
        // buffer one short, and zero capacity
        ob.status = ST_CAPACITY;
        r.item = make_item(64'sd0, 0, 16'd5, 0);    r.fixed = ob;        rows.push_back(r);
        r.item = make_item(64'sd0, 0, 16'd0, 0);    r.fixed = ob;        rows.push_back(r);
        // invalid arguments: scale too large, bad letters, nonzero terminator
        ob.status = ST_INVALID; ob.required_length = 7'd0;
        r.fixed = ob;
        r.item = make_item(64'sd1, 19, 16'd100, 0);                      rows.push_back(r);
        r.item = make_item(64'sd1, 255, 16'd100, 1);                     rows.push_back(r);
        r.item = make_item(64'sd1, 2, 16'd100, 0); r.item.code_first = "@";
        rows.push_back(r);
        r.item = make_item(64'sd1, 2, 16'd100, 0); r.item.code_second = "[";
        rows.push_back(r);
        r.item = make_item(64'sd1, 2, 16'd100, 0); r.item.code_third = "a";
        rows.push_back(r);
        r.item = make_item(64'sd1, 2, 16'd100, 0); r.item.code_terminator = 8'hFF;
        rows.push_back(r);
        r.item = make_item(64'sd1, 2, 16'd100, 0); r.item.code_first = 8'd0;
        rows.push_back(r);
        // letters at the range ends pass
        r.has_fixed = 0;
        r.item = make_item(64'sd7, 3, 16'd100, 0);
        r.item.code_first = CH_A; r.item.code_second = CH_Z; r.item.code_third = CH_A;
        rows.push_back(r);

        foreach (rows[i])
        begin
            if (rows[i].has_fixed)
            begin
                out_item_t chk[$];
                format_amount(rows[i].item, chk);
                if (chk.size() != 1 || chk[0] != rows[i].fixed)
                begin
                    $error("table row %0d: fixed expectation disagrees with predictor", i);
                    fail_count++;
                end
            end
            send_beat(rows[i].item);
        end

        // random part, with one long receiver hold-off in the middle
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2) hold_request = 1'b1;
            it = fit_capacity(random_item());
            send_beat(it);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls; hold off for a long stretch once on request.
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Check each accepted output beat against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (text_beats_q.size() == 0)
            begin
                $error("unexpected beat: %p", out_data);
                fail_count++;
            end
            else
            begin
                want = text_beats_q.pop_front();
                if (out_data.text_char !== want.text_char)
                begin
                    $error("text_char exp %h got %h", want.text_char, out_data.text_char);
                    fail_count++;
                end
                if (out_data.has_char !== want.has_char)
                begin
                    $error("has_char exp %b got %b", want.has_char, out_data.has_char);
                    fail_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last exp %b got %b", want.last, out_data.last);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, out_data.status);
                    fail_count++;
                end
                if (out_data.required_length !== want.required_length)
                begin
                    $error("required_length exp %0d got %0d",
                           want.required_length, out_data.required_length);
                    fail_count++;
                end
            end
        end
    end

    // Finish: drain, then settle; the cycle counter guards against a hang.
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (sending_done);
                while (text_beats_q.size() != 0) @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                fail_count++;
                $display("timeout after %0d cycles", cycle_count);
            end
        join_any
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
